// ===== rtl/core/qconv_pkg.sv =====
// Shared codes, sizes and types for the quantized 1D convolution engine.
`default_nettype none

package qconv_pkg;

    // Store geometry
    localparam int MAX_FILTERS  = 16;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_TAPS     = 16;
    localparam int MAX_LENGTH   = 256;

    localparam int FILT_W  = $clog2(MAX_FILTERS);
    localparam int CHAN_W  = $clog2(MAX_CHANNELS);
    localparam int TAP_W   = $clog2(MAX_TAPS);
    localparam int COL_W   = $clog2(MAX_LENGTH);
    localparam int ADDR_W  = 12;
    localparam int CNT_W   = 5;
    localparam int LEN_W   = 9;
    localparam int SHIFT_W = 5;

    // Accumulator: 256 products of 16 bits plus a 32-bit bias, signed
    localparam int ACC_W   = 34;
    localparam int PROD_W  = 16;

    localparam int OUT_MAX = 127;
    localparam int OUT_MIN = -128;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_WRITE_WEIGHT = 2'd0;
    localparam logic [1:0] OP_WRITE_BIAS   = 2'd1;
    localparam logic [1:0] OP_WRITE_ACT    = 2'd2;
    localparam logic [1:0] OP_COMPUTE      = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_FILTER_COUNT  = 3'd0;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] CFG_TAP_COUNT     = 3'd2;
    localparam logic [2:0] CFG_INPUT_LENGTH  = 3'd3;
    localparam logic [2:0] CFG_SHIFT_AMOUNT  = 3'd4;
    localparam logic [2:0] CFG_RELU_ENABLE   = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_BIAS  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/quantized_conv1d_engine_unit.sv =====
// Top level of the quantized int8 1D valid convolution engine.
// Write beats (weight, bias, activation) are absorbed only while idle. A compute beat
// may wait on m_tready before its result is taken: the
// weight and activation memories each deliver one entry per cycle, so one
// multiply-accumulate runs per cycle, then the pipeline drains, the bias is
// added and the shifted, saturated value is registered. An out-of-range
// query skips the multiply-accumulate and answers with range_error. The next beat is taken
// once the result is in the output register. Stores need no clearing pass;
// reading an entry that was never written returns unspecified data.
`default_nettype none

module quantized_conv1d_engine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // address[11:0], byte_value[19:12], bias_value[51:20],
    // query_filter[55:52], query_column[63:56]
    input  wire logic [63:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_tuser,
    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // result_value[7:0]
    output      logic [7:0]  m_tdata,
    // range_error[0]
    output      logic [0:0]  m_tuser
);

    localparam int WDEPTH = qconv_pkg::MAX_FILTERS * qconv_pkg::MAX_CHANNELS
                            * qconv_pkg::MAX_TAPS;
    localparam int ADEPTH = qconv_pkg::MAX_LENGTH * qconv_pkg::MAX_CHANNELS;

    // Beat fields
    logic [qconv_pkg::ADDR_W-1:0] in_address;
    logic signed [7:0]            in_byte;
    logic signed [31:0]           in_bias;
    logic [qconv_pkg::FILT_W-1:0] in_filter;
    logic [qconv_pkg::COL_W-1:0]  in_column;
    logic [1:0]                   in_op;

    assign in_address = s_tdata[11:0];
    assign in_byte    = s_tdata[19:12];
    assign in_bias    = s_tdata[51:20];
    assign in_filter  = s_tdata[55:52];
    assign in_column  = s_tdata[63:56];
    assign in_op      = s_tuser;

    // Configuration registers
    logic [qconv_pkg::CNT_W-1:0]   filter_count_reg;
    logic [qconv_pkg::CNT_W-1:0]   channel_count_reg;
    logic [qconv_pkg::CNT_W-1:0]   tap_count_reg;
    logic [qconv_pkg::LEN_W-1:0]   input_length_reg;
    logic [qconv_pkg::SHIFT_W-1:0] shift_amount_reg;
    logic                          relu_enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_count_reg  <= qconv_pkg::CNT_W'(1);
            channel_count_reg <= qconv_pkg::CNT_W'(1);
            tap_count_reg     <= qconv_pkg::CNT_W'(1);
            input_length_reg  <= qconv_pkg::LEN_W'(1);
            shift_amount_reg  <= '0;
            relu_enable_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                qconv_pkg::CFG_FILTER_COUNT:  filter_count_reg  <= cfg_data[4:0];
                qconv_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[4:0];
                qconv_pkg::CFG_TAP_COUNT:     tap_count_reg     <= cfg_data[4:0];
                qconv_pkg::CFG_INPUT_LENGTH:  input_length_reg  <= cfg_data;
                qconv_pkg::CFG_SHIFT_AMOUNT:  shift_amount_reg  <= cfg_data[4:0];
                qconv_pkg::CFG_RELU_ENABLE:   relu_enable_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control state
    qconv_pkg::state_t state_reg, state_next;
    logic [qconv_pkg::FILT_W-1:0] filter_reg, filter_next;
    logic [qconv_pkg::COL_W-1:0]  column_reg, column_next;
    logic [qconv_pkg::CHAN_W-1:0] chan_reg, chan_next;
    logic [qconv_pkg::TAP_W-1:0]  tap_reg, tap_next;
    logic                         err_reg, err_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         prod_valid_reg;

    logic in_accept;
    logic query_bad;
    logic last_mac;
    logic load_out;
    logic weight_we, bias_we, act_we;

    assign s_tready  = (state_reg == qconv_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign weight_we = in_accept && (in_op == qconv_pkg::OP_WRITE_WEIGHT);
    assign bias_we   = in_accept && (in_op == qconv_pkg::OP_WRITE_BIAS)
                       && (in_address[11:qconv_pkg::FILT_W] == '0);
    assign act_we    = in_accept && (in_op == qconv_pkg::OP_WRITE_ACT);

    always_comb begin
        logic [9:0] window_end;
        window_end = 10'(in_column) + 10'(tap_count_reg);
        query_bad = (filter_count_reg == '0)
                 || (filter_count_reg > qconv_pkg::CNT_W'(qconv_pkg::MAX_FILTERS))
                 || (channel_count_reg == '0)
                 || (channel_count_reg > qconv_pkg::CNT_W'(qconv_pkg::MAX_CHANNELS))
                 || (tap_count_reg == '0)
                 || (tap_count_reg > qconv_pkg::CNT_W'(qconv_pkg::MAX_TAPS))
                 || (input_length_reg == '0)
                 || (input_length_reg > qconv_pkg::LEN_W'(qconv_pkg::MAX_LENGTH))
                 || (qconv_pkg::CNT_W'(in_filter) >= filter_count_reg)
                 || (window_end > 10'(input_length_reg));
    end

    assign last_mac = (qconv_pkg::CNT_W'(chan_reg) + qconv_pkg::CNT_W'(1)
                       == channel_count_reg)
                   && (qconv_pkg::CNT_W'(tap_reg) + qconv_pkg::CNT_W'(1)
                       == tap_count_reg);

    assign load_out = (state_reg == qconv_pkg::ST_OUT) && (!m_tvalid || m_tready);

    always_comb begin
        state_next   = state_reg;
        filter_next  = filter_reg;
        column_next  = column_reg;
        chan_next    = chan_reg;
        tap_next     = tap_reg;
        err_next     = err_reg;
        rd_pend_next = (state_reg == qconv_pkg::ST_RUN);
        case (state_reg)
            qconv_pkg::ST_IDLE: begin
                if (in_accept && (in_op == qconv_pkg::OP_COMPUTE)) begin
                    filter_next = in_filter;
                    column_next = in_column;
                    chan_next   = '0;
                    tap_next    = '0;
                    err_next    = query_bad;
                    state_next  = query_bad ? qconv_pkg::ST_OUT : qconv_pkg::ST_RUN;
                end
            end
            qconv_pkg::ST_RUN: begin
                // walk taps inside channels, one read pair per cycle
                if (last_mac) begin
                    state_next = qconv_pkg::ST_DRAIN;
                end else if (qconv_pkg::CNT_W'(tap_reg) + qconv_pkg::CNT_W'(1)
                             == tap_count_reg) begin
                    tap_next  = '0;
                    chan_next = chan_reg + qconv_pkg::CHAN_W'(1);
                end else begin
                    tap_next = tap_reg + qconv_pkg::TAP_W'(1);
                end
            end
            qconv_pkg::ST_DRAIN: begin
                if (!rd_pend_reg && !prod_valid_reg) begin
                    state_next = qconv_pkg::ST_BIAS;
                end
            end
            qconv_pkg::ST_BIAS: begin
                state_next = qconv_pkg::ST_OUT;
            end
            qconv_pkg::ST_OUT: begin
                if (load_out) begin
                    state_next = qconv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qconv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= qconv_pkg::ST_IDLE;
            err_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            err_reg     <= err_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        filter_reg <= filter_next;
        column_reg <= column_next;
        chan_reg   <= chan_next;
        tap_reg    <= tap_next;
    end

    // Memories: writes only in idle; reads run every cycle, only those made while running are used
    logic [qconv_pkg::ADDR_W-1:0] weight_raddr, act_raddr;
    logic [qconv_pkg::COL_W-1:0]  act_column;

    assign act_column   = column_reg + qconv_pkg::COL_W'(tap_reg);
    assign weight_raddr = {filter_reg, chan_reg, tap_reg};
    assign act_raddr    = {act_column, chan_reg};

    logic signed [7:0]  weight_mem [WDEPTH];
    logic signed [7:0]  act_mem    [ADEPTH];
    logic signed [31:0] bias_mem   [qconv_pkg::MAX_FILTERS];
    logic signed [7:0]  weight_q;
    logic signed [7:0]  act_q;
    logic signed [31:0] bias_q;

    always_ff @(posedge aclk) begin
        if (weight_we) begin
            weight_mem[in_address] <= in_byte;
        end
        weight_q <= weight_mem[weight_raddr];
    end

    always_ff @(posedge aclk) begin
        if (act_we) begin
            act_mem[in_address] <= in_byte;
        end
        act_q <= act_mem[act_raddr];
    end

    always_ff @(posedge aclk) begin
        if (bias_we) begin
            bias_mem[in_address[qconv_pkg::FILT_W-1:0]] <= in_bias;
        end
        bias_q <= bias_mem[filter_reg];
    end

    // Multiply, then accumulate
    logic signed [qconv_pkg::PROD_W-1:0] prod_reg;
    logic signed [qconv_pkg::ACC_W-1:0]  acc_reg, acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= rd_pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= weight_q * act_q;
    end

    always_comb begin
        acc_next = acc_reg;
        if (in_accept) begin
            acc_next = '0;
        end else if (prod_valid_reg) begin
            acc_next = acc_reg + qconv_pkg::ACC_W'(prod_reg);
        end else if (state_reg == qconv_pkg::ST_BIAS) begin
            acc_next = acc_reg + qconv_pkg::ACC_W'(bias_q);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Shift, saturate, rectify
    logic signed [qconv_pkg::ACC_W-1:0] shifted;
    logic signed [7:0]                  sat_value;
    logic signed [7:0]                  final_value;

    assign shifted = acc_reg >>> shift_amount_reg;

    always_comb begin
        if (shifted > qconv_pkg::ACC_W'(qconv_pkg::OUT_MAX)) begin
            sat_value = 8'(qconv_pkg::OUT_MAX);
        end else if (shifted < qconv_pkg::ACC_W'(qconv_pkg::OUT_MIN)) begin
            sat_value = 8'(qconv_pkg::OUT_MIN);
        end else begin
            sat_value = shifted[7:0];
        end
        if (err_reg || (relu_enable_reg && (sat_value <= 8'sd0))) begin
            final_value = '0;
        end else begin
            final_value = sat_value;
        end
    end

    // Output register
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= final_value;
            m_err_reg  <= err_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_err_reg;

    // Checks
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qconv_pkg::ST_IDLE) |-> (!rd_pend_reg && !prod_valid_reg))
        else $error("MAC pipeline busy while idle");

    a_store_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (weight_we || act_we || bias_we) |-> (state_reg == qconv_pkg::ST_IDLE))
        else $error("store written during compute");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_tready))
        else $error("held result overwritten");

    a_bias_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qconv_pkg::ST_BIAS) |-> !prod_valid_reg)
        else $error("bias added before products drained");

endmodule

`default_nettype wire
